FILE: rtl/itp_pkg.sv
// Shared types and constants of the infix-to-postfix converter.
`timescale 1ns / 1ps

package itp_pkg;

  // Stack and token geometry
  localparam int STACK_DEPTH = 32;
  localparam int VALUE_WIDTH = 16;
  localparam int TYPE_WIDTH  = 8;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ENTRY_W     = TYPE_WIDTH + VALUE_WIDTH;
  localparam int DATA_W      = ((ENTRY_W + 7) / 8) * 8;

  // Token class, type bits 7:6
  typedef enum logic [1:0] {
    CLS_OPERAND  = 2'b00,
    CLS_OPERATOR = 2'b01,
    CLS_OPEN     = 2'b10,
    CLS_CLOSE    = 2'b11
  } cls_e;

  // Type bits 7:5 of stacked open parenthesis and function entries
  localparam logic [2:0] TAG_OPEN = 3'b100;
  localparam logic [2:0] TAG_FUNC = 3'b101;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_TOKEN     = 2'd0,
    STAT_DONE      = 2'd1,
    STAT_UNMATCHED = 2'd2,
    STAT_OVERFLOW  = 2'd3
  } stat_e;

  // Source of a produced result
  typedef enum logic [1:0] {
    RES_TOK = 2'd0,
    RES_TOP = 2'd1,
    RES_OVF = 2'd2,
    RES_END = 2'd3
  } res_sel_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic     load_tok;
    logic     produce;
    res_sel_e res_sel;
    logic     pop;
    logic     push;
    logic     set_err;
    logic     set_unm;
    logic     clr_flags;
    logic     finish;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic pend_v;
    logic out_free;
    logic can_produce;
    logic empty;
    logic full;
    logic pop_ok;
    logic top_open;
    logic top_func;
    logic in_mode;
    cls_e in_class;
  } sts_t;

endpackage

FILE: rtl/infix_to_postfix_converter.sv
// Top level of the infix-to-postfix converter.
`timescale 1ns / 1ps

// Shunting-yard converter: each input transfer is a token (or, with tuser set, an
// end-of-expression marker) and the block sends tokens out in postfix order, with
// tlast on the last result each input causes and a status code in tuser. An operand
// is passed through; an operator or open parenthesis is pushed after the operators
// it pops; a close parenthesis pops entries down to the matching parenthesis, which
// is dropped, and then a trailing function; a flush pops every stacked entry, then
// reports the status. The single-ported operator stack moves one entry per cycle
// unless a result stalls. A result waits in a pending register until the controller
// knows whether it is the last one, so the last result of an item moves to the
// output register when the controller is back in idle, the same cycle the next item
// can be taken. Results stall when the sink drops tready; the stack holds
// STACK_DEPTH entries and needs no clearing after reset.
module infix_to_postfix_converter import itp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [DATA_W-1:0] s_axis_tdata_i,   // token_type[7:0], token_value[23:8]
  input  logic              s_axis_tuser_i,   // mode
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [DATA_W-1:0] m_axis_tdata_o,   // out_type[7:0], out_value[23:8]
  output logic [1:0]        m_axis_tuser_o,   // status
  output logic              m_axis_tlast_o
);

  cmd_t cmd;
  sts_t sts;

  itp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  itp_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .m_tready_i (m_axis_tready_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tuser_o  (m_axis_tuser_o),
    .m_tlast_o  (m_axis_tlast_o)
  );

endmodule

FILE: rtl/itp_datapath.sv
// Datapath of the infix-to-postfix converter: token, stack, flags and result stages.
`timescale 1ns / 1ps

module itp_datapath import itp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [DATA_W-1:0] s_tdata_i,   // token_type[7:0], token_value[23:8]
  input  logic              s_tuser_i,   // mode
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic              m_tready_i,
  output logic              m_tvalid_o,
  output logic [DATA_W-1:0] m_tdata_o,   // out_type[7:0], out_value[23:8]
  output logic [1:0]        m_tuser_o,   // status
  output logic              m_tlast_o
);

  logic [TYPE_WIDTH-1:0]  tok_type_q;
  logic [VALUE_WIDTH-1:0] tok_value_q;
  logic [ENTRY_W-1:0]     stack_q [STACK_DEPTH];
  logic [CNT_W-1:0]       count_q, count_d, count_dec, next_top;
  logic [PTR_W-1:0]       push_idx;
  logic                   err_q, err_d, unm_q, unm_d;
  logic [ENTRY_W-1:0]     top_q;
  logic [TYPE_WIDTH-1:0]  top_type;
  logic                   prec_pop;

  logic                   pend_v_q, pend_v_d;
  logic [TYPE_WIDTH-1:0]  pend_type_q;
  logic [VALUE_WIDTH-1:0] pend_value_q;
  stat_e                  pend_stat_q;
  logic                   out_v_q, out_v_d;
  logic [TYPE_WIDTH-1:0]  out_type_q;
  logic [VALUE_WIDTH-1:0] out_value_q;
  stat_e                  out_stat_q;
  logic                   out_last_q;
  logic                   out_load, out_free;

  logic [TYPE_WIDTH-1:0]  res_type;
  logic [VALUE_WIDTH-1:0] res_value;
  stat_e                  res_stat;

  // Stack addressing; the top entry is read ahead into top_q for the next count
  assign count_dec = count_q - CNT_W'(1);
  assign next_top  = count_d - CNT_W'(1);
  assign push_idx  = count_q[PTR_W-1:0];
  assign top_type  = top_q[TYPE_WIDTH-1:0];

  // Incoming operator pops a stacked operator that binds as strong (right-assoc: stronger)
  always_comb begin
    if (tok_type_q[5]) begin
      prec_pop = tok_type_q[4:0] < top_type[4:0];
    end else begin
      prec_pop = tok_type_q[4:0] <= top_type[4:0];
    end
  end

  // Status to the controller
  assign out_free = !out_v_q || m_tready_i;
  always_comb begin
    sts_o.pend_v      = pend_v_q;
    sts_o.out_free    = out_free;
    sts_o.can_produce = !pend_v_q || out_free;
    sts_o.empty       = (count_q == '0);
    sts_o.full        = (count_q == CNT_W'(STACK_DEPTH));
    sts_o.pop_ok      = (tok_type_q[7:6] == CLS_OPERATOR) && (count_q != '0) &&
                        (top_type[7:6] == CLS_OPERATOR) && prec_pop;
    sts_o.top_open    = (top_type[7:5] == TAG_OPEN);
    sts_o.top_func    = (top_type[7:5] == TAG_FUNC);
    sts_o.in_mode     = s_tuser_i;
    sts_o.in_class    = cls_e'(s_tdata_i[7:6]);
  end

  // Select the result being produced
  always_comb begin
    unique case (cmd_i.res_sel)
      RES_TOK: begin
        res_type  = tok_type_q;
        res_value = tok_value_q;
        res_stat  = STAT_TOKEN;
      end
      RES_TOP: begin
        res_type  = top_type;
        res_value = top_q[ENTRY_W-1:TYPE_WIDTH];
        res_stat  = STAT_TOKEN;
      end
      RES_OVF: begin
        res_type  = tok_type_q;
        res_value = tok_value_q;
        res_stat  = STAT_OVERFLOW;
      end
      RES_END: begin
        res_type  = '0;
        res_value = '0;
        if (err_q) begin
          res_stat = STAT_OVERFLOW;
        end else if (unm_q) begin
          res_stat = STAT_UNMATCHED;
        end else begin
          res_stat = STAT_DONE;
        end
      end
    endcase
  end

  // Next values of control state
  always_comb begin
    count_d = count_q;
    if (cmd_i.push) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.pop) begin
      count_d = count_dec;
    end

    err_d = (err_q || cmd_i.set_err) && !cmd_i.clr_flags;
    unm_d = (unm_q || cmd_i.set_unm) && !cmd_i.clr_flags;

    // A new result pushes the pending one out as not-last; finish sends it as last
    out_load = (cmd_i.produce && pend_v_q) || cmd_i.finish;
    pend_v_d = pend_v_q;
    if (cmd_i.produce) begin
      pend_v_d = 1'b1;
    end else if (cmd_i.finish) begin
      pend_v_d = 1'b0;
    end

    out_v_d = out_v_q;
    if (out_load) begin
      out_v_d = 1'b1;
    end else if (m_tready_i) begin
      out_v_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      err_q    <= 1'b0;
      unm_q    <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      count_q  <= count_d;
      err_q    <= err_d;
      unm_q    <= unm_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_tok) begin
      tok_type_q  <= s_tdata_i[TYPE_WIDTH-1:0];
      tok_value_q <= s_tdata_i[ENTRY_W-1:TYPE_WIDTH];
    end
    if (cmd_i.produce) begin
      pend_type_q  <= res_type;
      pend_value_q <= res_value;
      pend_stat_q  <= res_stat;
    end
    if (out_load) begin
      out_type_q  <= pend_type_q;
      out_value_q <= pend_value_q;
      out_stat_q  <= pend_stat_q;
      out_last_q  <= cmd_i.finish;
    end
  end

  // Operator stack memory; a push also forwards the new entry as the top
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      stack_q[push_idx] <= {tok_value_q, tok_type_q};
      top_q             <= {tok_value_q, tok_type_q};
    end else begin
      top_q             <= stack_q[next_top[PTR_W-1:0]];
    end
  end

  // Output port
  assign m_tvalid_o = out_v_q;
  assign m_tdata_o  = DATA_W'({out_value_q, out_type_q});
  assign m_tuser_o  = out_stat_q;
  assign m_tlast_o  = out_last_q;

endmodule

FILE: rtl/itp_ctrl.sv
// Controller state machine of the infix-to-postfix converter.
`timescale 1ns / 1ps

module itp_ctrl import itp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_tvalid_i,
  output logic s_tready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_EMIT  = 6'b000010,
    ST_OPER  = 6'b000100,
    ST_CLOSE = 6'b001000,
    ST_FUNC  = 6'b010000,
    ST_FLUSH = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;

    unique case (state_q)
      // Release the last result of the previous item and take the next transfer
      ST_IDLE: begin
        s_tready_o   = !sts_i.pend_v || sts_i.out_free;
        cmd_o.finish = sts_i.pend_v && sts_i.out_free;
        if (s_tvalid_i && s_tready_o) begin
          cmd_o.load_tok = 1'b1;
          if (sts_i.in_mode) begin
            state_d = ST_FLUSH;
          end else begin
            unique case (sts_i.in_class)
              CLS_OPERAND:  state_d = ST_EMIT;
              CLS_OPERATOR: state_d = ST_OPER;
              CLS_OPEN:     state_d = ST_OPER;
              CLS_CLOSE:    state_d = ST_CLOSE;
            endcase
          end
        end
      end

      // Pass an operand through
      ST_EMIT: begin
        if (sts_i.can_produce) begin
          cmd_o.produce = 1'b1;
          cmd_o.res_sel = RES_TOK;
          state_d       = ST_IDLE;
        end
      end

      // Pop stronger operators (equal ones too when left-assoc), then push or flag overflow
      ST_OPER: begin
        if (sts_i.pop_ok) begin
          if (sts_i.can_produce) begin
            cmd_o.produce = 1'b1;
            cmd_o.res_sel = RES_TOP;
            cmd_o.pop     = 1'b1;
          end
        end else if (sts_i.full) begin
          if (sts_i.can_produce) begin
            cmd_o.produce = 1'b1;
            cmd_o.res_sel = RES_OVF;
            cmd_o.set_err = 1'b1;
            state_d       = ST_IDLE;
          end
        end else begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end
      end

      // Drain down to the matching open parenthesis and drop it
      ST_CLOSE: begin
        if (sts_i.empty) begin
          state_d = ST_IDLE;
        end else if (sts_i.top_open) begin
          cmd_o.pop = 1'b1;
          state_d   = ST_FUNC;
        end else if (sts_i.can_produce) begin
          cmd_o.produce = 1'b1;
          cmd_o.res_sel = RES_TOP;
          cmd_o.pop     = 1'b1;
        end
      end

      // Emit a function that owns the closed parenthesis pair
      ST_FUNC: begin
        if (!sts_i.empty && sts_i.top_func) begin
          if (sts_i.can_produce) begin
            cmd_o.produce = 1'b1;
            cmd_o.res_sel = RES_TOP;
            cmd_o.pop     = 1'b1;
            state_d       = ST_IDLE;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end

      // Drain the stack, then report the expression status
      ST_FLUSH: begin
        if (sts_i.empty) begin
          if (sts_i.can_produce) begin
            cmd_o.produce   = 1'b1;
            cmd_o.res_sel   = RES_END;
            cmd_o.clr_flags = 1'b1;
            state_d         = ST_IDLE;
          end
        end else if (sts_i.top_open) begin
          cmd_o.pop     = 1'b1;
          cmd_o.set_unm = 1'b1;
        end else if (sts_i.can_produce) begin
          cmd_o.produce = 1'b1;
          cmd_o.res_sel = RES_TOP;
          cmd_o.pop     = 1'b1;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/itp_checker.sv
// Port-level checks of the infix-to-postfix converter, bound to the top level.
`timescale 1ns / 1ps

module itp_checker import itp_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid_i,
  input logic              s_axis_tready_o,
  input logic              m_axis_tvalid_o,
  input logic              m_axis_tready_i,
  input logic [DATA_W-1:0] m_axis_tdata_o,
  input logic [1:0]        m_axis_tuser_o,
  input logic              m_axis_tlast_o
);

  // Status results close the item that caused them
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != STAT_TOKEN) |-> m_axis_tlast_o)
    else $error("status result without tlast");

  // End-of-expression results carry no token
  a_end_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && ((m_axis_tuser_o == STAT_DONE) || (m_axis_tuser_o == STAT_UNMATCHED))
    |-> (m_axis_tdata_o == '0))
    else $error("end result with nonzero data");

  // Parentheses never appear as postfix tokens
  a_no_paren: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == STAT_TOKEN)
    |-> (m_axis_tdata_o[7:5] != TAG_OPEN) && (m_axis_tdata_o[7:6] != CLS_CLOSE))
    else $error("parenthesis emitted as token");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) &&
    $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))
    else $error("stalled result changed");

  // An input transfer is followed by a cycle without tready
  a_in_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken on consecutive cycles");

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
